@@ rtl/i2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_pkg: shared types and constants for the radix digit converter
// Holds the sequencer state type, digit widths and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package i2r_pkg;

    // Digit and character widths.
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int RADIX_W     = 6;
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int FIELD_W     = 32;

    // Legal radix range; inputs outside it saturate.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    // Character constants.
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    // Map a digit 0..35 onto '0'..'9', 'A'..'Z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = ASCII_ZERO + CHAR_W'(d);
        end else begin
            c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/i2r_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_div: iterative restoring divider by a small radix
// Divides a W-bit value by a 6-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module i2r_div #(
    parameter int W = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [W-1:0]                  i_dividend,
    input  wire logic [i2r_pkg::RADIX_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [W-1:0]                       o_quot,
    output logic [i2r_pkg::DIGIT_W-1:0]        o_rem
);
    import i2r_pkg::*;

    localparam int CW = $clog2(W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [W-1:0]         r_quot, n_quot;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [RADIX_W-1:0]   r_div, n_div;
    logic [DIGIT_W:0]     w_trial;
    logic                 w_fit;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign w_trial = {r_rem, r_quot[W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (r_busy) begin
            n_quot = {r_quot[W-2:0], w_fit};
            n_rem  = w_fit ? DIGIT_W'(w_trial - {1'b0, r_div}) : w_trial[DIGIT_W-1:0];
            n_cnt  = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = CW'(W - 1);
        end
    end

    // Control state resets; the datapath does not need to.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ rtl/i2r_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_store: digit store memory
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module i2r_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [i2r_pkg::ADDR_W-1:0]    i_wr_addr,
    input  wire logic [i2r_pkg::DIGIT_W-1:0]   i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [i2r_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [i2r_pkg::DIGIT_W-1:0]        o_rd_data
);
    import i2r_pkg::*;

    logic [DIGIT_W-1:0] r_mem [STORE_DEPTH];
    logic [DIGIT_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/integer_to_radix_digits_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Timing: each digit comes from a bit-serial divider of width W' = min(VALUE_WIDTH, 32); a zero
// value skips the divider and puts its single digit out directly from the store.
// Flow: busy stays high until the last digit is read from the store, and a new transaction
// is accepted only while busy is low, so one conversion is in flight at a time.
// Results cannot be stalled. Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top: unsigned integer to radix ASCII digits
// Repeatedly divides the value by the radix, stores the remainders, then
// emits them most significant first with a flag on the last digit.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [i2r_pkg::FIELD_W-1:0]   i_value,
    input  wire logic [i2r_pkg::RADIX_W-1:0]   i_radix,
    output logic                               o_valid,
    output logic [i2r_pkg::CHAR_W-1:0]         o_digit_char,
    output logic                               o_last_digit
);
    import i2r_pkg::*;

    localparam int WW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    t_state               r_state, n_state;
    logic [RADIX_W-1:0]   r_radix, n_radix;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]    r_rd_idx, n_rd_idx;
    logic                 r_valid, n_valid;
    logic                 r_last, n_last;

    logic                 w_accept;
    logic [WW-1:0]        w_value;
    logic [RADIX_W-1:0]   w_radix;
    logic                 w_div_start;
    logic [WW-1:0]        w_div_dividend;
    logic                 w_div_done;
    logic [WW-1:0]        w_div_quot;
    logic [DIGIT_W-1:0]   w_div_rem;
    logic                 w_wr_en;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [DIGIT_W-1:0]   w_wr_data;
    logic                 w_rd_en;
    logic [DIGIT_W-1:0]   w_rd_data;

    // Input transaction and operand conditioning.
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_value  = i_value[WW-1:0];
    assign w_radix  = (i_radix < RADIX_MIN) ? RADIX_MIN :
                      (i_radix > RADIX_MAX) ? RADIX_MAX : i_radix;

    // Sequencer.
    always_comb begin
        n_state        = r_state;
        n_radix        = r_radix;
        n_count        = r_count;
        n_rd_idx       = r_rd_idx;
        n_valid        = 1'b0;
        n_last         = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = w_value;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_count[ADDR_W-1:0];
        w_wr_data      = w_div_rem;
        w_rd_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_radix = w_radix;
                    if (w_value == '0) begin
                        // A zero value is the single digit zero.
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = '0;
                        n_count   = COUNT_W'(1);
                        n_rd_idx  = '0;
                        n_state   = S_EMIT;
                    end else begin
                        w_div_start = 1'b1;
                        n_count     = '0;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    // Store the remainder; continue on the quotient until it is zero.
                    w_wr_en = 1'b1;
                    n_count = r_count + COUNT_W'(1);
                    if (w_div_quot == '0) begin
                        n_rd_idx = r_count[ADDR_W-1:0];
                        n_state  = S_EMIT;
                    end else begin
                        w_div_start    = 1'b1;
                        w_div_dividend = w_div_quot;
                    end
                end
            end
            S_EMIT: begin
                // Read digits from the top of the store down to entry zero.
                w_rd_en  = 1'b1;
                n_valid  = 1'b1;
                n_last   = (r_rd_idx == '0);
                n_rd_idx = r_rd_idx - ADDR_W'(1);
                if (r_rd_idx == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix  <= n_radix;
        r_rd_idx <= n_rd_idx;
    end

    // Shared divider.
    i2r_div #(
        .W (WW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  ((r_state == S_IDLE) ? w_radix : r_radix),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // Digit store.
    i2r_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    // Result transaction.
    assign o_valid      = r_valid;
    assign o_digit_char = digit_to_ascii(w_rd_data);
    assign o_last_digit = r_last;

endmodule
`default_nettype wire

@@ dv/integer_to_radix_digits_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top_test: self-checking bench for the digit converter
// Sends values with bases in and out of the legal range, predicts the ASCII
// digit string of each one and checks every emitted digit and its last flag.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top_test;

    import i2r_pkg::*;

    // One conversion request as it is driven into the block.
    typedef struct {
        logic [FIELD_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_conversion;

    // One emitted digit as it should appear on the result ports.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_digit_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic [FIELD_W-1:0] i_value      = '0;
    logic [RADIX_W-1:0] i_radix      = '0;
    logic               busy;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_digit_char;
    logic               o_last_digit;

    t_conversion        conversions_waiting[$];
    t_digit_result      expected_digits[$];

    int unsigned        mismatch_count  = 0;
    int unsigned        converted_count = 0;
    int unsigned        digits_checked  = 0;
    int unsigned        saturated_count = 0;
    int unsigned        longest_string  = 0;
    int unsigned        burst_left      = 1;
    int unsigned        gap_left        = 0;

    integer_to_radix_digits_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Queue a conversion request for the driver.
    task automatic queue_conversion(input logic [FIELD_W-1:0] value,
                                    input logic [RADIX_W-1:0] radix);
        t_conversion req;
        req.value = value;
        req.radix = radix;
        conversions_waiting.push_back(req);
    endtask

    // Work out the digit string of one accepted value, most significant first.
    task automatic predict_digits(input logic [FIELD_W-1:0] value,
                                  input logic [RADIX_W-1:0] radix);
        int unsigned   base;
        logic [31:0]   rest;
        logic [5:0]    remainders[$];
        t_digit_result res;
        int            i;
        base = 32'(radix);
        if (base < 2 || base > 36) begin
            saturated_count++;
        end
        if (base < 2) begin
            base = 2;
        end
        if (base > 36) begin
            base = 36;
        end
        rest = value;
        if (rest == 0) begin
            remainders.push_back(6'd0);
        end
        while (rest != 0) begin
            remainders.push_back(6'(rest % base));
            rest = rest / base;
        end
        if (remainders.size() > longest_string) begin
            longest_string = remainders.size();
        end
        for (i = remainders.size() - 1; i >= 0; i--) begin
            if (remainders[i] < DEC_DIGITS) begin
                res.ch = ASCII_ZERO + CHAR_W'(remainders[i]);
            end else begin
                res.ch = ASCII_A + CHAR_W'(remainders[i] - DEC_DIGITS);
            end
            res.last = (i == 0);
            expected_digits.push_back(res);
        end
    endtask

    // Driver: records each accepted transaction and presents the next request
    // in bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : driver
        logic took;
        took = start && !busy;
        if (took) begin
            predict_digits(i_value, i_radix);
            conversions_waiting.pop_front();
            converted_count++;
        end
        if (i_rst_n && !(start && !took)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (conversions_waiting.size() > 0) begin
                i_value <= conversions_waiting[0].value;
                i_radix <= conversions_waiting[0].radix;
                start   <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 5);
                        2: gap_left = $urandom_range(5, 40);
                        default: gap_left = $urandom_range(40, 200);
                    endcase
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed digit is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_digit_result want;
        if (i_rst_n && o_valid) begin
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit: expected none, actual char %h last %b",
                         $time, o_digit_char, o_last_digit);
                mismatch_count++;
            end else begin
                want = expected_digits.pop_front();
                digits_checked++;
                if (o_digit_char !== want.ch) begin
                    $display("%0t: digit_char mismatch: expected %h, actual %h",
                             $time, want.ch, o_digit_char);
                    mismatch_count++;
                end
                if (o_last_digit !== want.last) begin
                    $display("%0t: last_digit mismatch: expected %b, actual %b",
                             $time, want.last, o_last_digit);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        logic [FIELD_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int                 n;

        // Directed cases: zero, field extremes, radix saturation at both ends.
        queue_conversion(32'd0, 6'd10);
        queue_conversion(32'd0, 6'd0);
        queue_conversion(32'd0, 6'd63);
        queue_conversion(32'hFFFF_FFFF, 6'd2);
        queue_conversion(32'hFFFF_FFFF, 6'd36);
        queue_conversion(32'hFFFF_FFFF, 6'd63);
        queue_conversion(32'hFFFF_FFFF, 6'd0);
        queue_conversion(32'd5, 6'd1);
        queue_conversion(32'd1295, 6'd37);
        queue_conversion(32'hDEAD_BEEF, 6'd16);
        queue_conversion(32'hFFFF_FFFF, 6'd10);
        queue_conversion(32'd35, 6'd36);
        queue_conversion(32'd36, 6'd36);
        queue_conversion(32'd3486784401, 6'd3);
        queue_conversion(32'h8000_0000, 6'd2);
        queue_conversion(32'h5555_5555, 6'd4);
        queue_conversion(32'hAAAA_AAAA, 6'd8);
        queue_conversion(32'd9, 6'd10);
        queue_conversion(32'd10, 6'd10);
        queue_conversion(32'd1, 6'd2);
        queue_conversion(32'd123456789, 6'd35);
        queue_conversion(32'h7FFF_FFFF, 6'd31);

        // Random part: mixed magnitudes, mostly legal bases.
        for (n = 0; n < 208; n++) begin
            case ($urandom_range(0, 9))
                0: value = '0;
                1: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
                2, 3: value = $urandom_range(0, 1000);
                default: value = $urandom() >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
                0: radix = RADIX_W'($urandom_range(0, 1));
                1: radix = RADIX_W'($urandom_range(37, 63));
                default: radix = RADIX_W'($urandom_range(2, 36));
            endcase
            queue_conversion(value, radix);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (conversions_waiting.size() != 0 || expected_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        $display("tb: converted %0d values into %0d checked digits, longest string %0d",
                 converted_count, digits_checked, longest_string);
        $display("tb: %0d values used an out-of-range radix, %0d mismatches",
                 saturated_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #25_000_000;
        $display("tb: timeout with %0d requests and %0d digits outstanding",
                 conversions_waiting.size(), expected_digits.size());
        $display("tb: failure");
        $finish;
    end

endmodule

@@ integer_to_radix_digits_top.f @@
rtl/i2r_pkg.sv
rtl/i2r_div.sv
rtl/i2r_store.sv
rtl/integer_to_radix_digits_top.sv
dv/integer_to_radix_digits_top_test.sv
